/* hdl/ffa_pkg.sv */
`default_nettype none

package ffa_pkg;

   localparam int ADDR_W = 32;

   // descriptor kinds
   localparam logic [1:0] KIND_SPARE = 2'd0;
   localparam logic [1:0] KIND_FREE  = 2'd1;
   localparam logic [1:0] KIND_USED  = 2'd2;

   // request modes
   localparam logic [1:0] MODE_ALLOC     = 2'd0;
   localparam logic [1:0] MODE_ALLOC_AL  = 2'd1;
   localparam logic [1:0] MODE_FREE      = 2'd2;
   localparam logic [1:0] MODE_FREE_AL   = 2'd3;

   // result codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NOFIT    = 3'd1;
   localparam logic [2:0] ST_NOTALLOC = 3'd2;
   localparam logic [2:0] ST_OVERLAP  = 3'd3;
   localparam logic [2:0] ST_NODESC   = 3'd4;
   localparam logic [2:0] ST_BADALIGN = 3'd5;

   // register indexes
   localparam logic [1:0] CSR_POOL_BASE = 2'd0;
   localparam logic [1:0] CSR_POOL_LEN  = 2'd1;
   localparam logic [1:0] CSR_MIN_SPLIT = 2'd2;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] aligned_base;
      logic [ADDR_W-1:0] length;
      logic [ADDR_W-1:0] base;
   } hole_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [ADDR_W-1:0] request_size;
      logic [5:0]        align_exponent;
      logic [ADDR_W-1:0] block_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] granted_address;
      logic [2:0]        status;
   } rsp_type;

endpackage

`default_nettype wire

/* hdl/ffa_ram.sv */
`default_nettype none

module ffa_ram #(
   parameter int WIDTH = 98,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* hdl/first_fit_coalescing_allocator.sv */
`default_nettype none
// Allocate: one table pass, a decision step and up to two write-backs, then the result
// strobe. Free: match pass, neighbor pass, decision and up to three write-backs, then
// the result strobe. Bad alignment or oversized size answers the next cycle.
// One request at a time; busy drops with the result strobe. Reset and each pool base or
// length write run a clearing pass over every descriptor, busy high. The receiver cannot stall.

module first_fit_coalescing_allocator
   import ffa_pkg::*;
#(
   parameter int DESC_COUNT = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire req_type    req_payload,
   output logic            rsp_valid,
   output rsp_type         rsp_payload,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int IDX_W = $clog2(DESC_COUNT);
   localparam int HW    = $bits(hole_type);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DESC_COUNT - 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ASCAN, S_ADEC, S_MSCAN, S_NSTART, S_NSCAN, S_FDEC, S_WRITE
   } state_type;

   state_type         state_ff;
   logic [31:0]       pool_base_ff, pool_len_ff, min_split_ff;
   req_type           req_ff;
   logic [IDX_W-1:0]  clr_ff;

   // scan engine
   logic              issue_ff, dv_ff, dlast_ff;
   logic [IDX_W-1:0]  saddr_ff, didx_ff;

   // alloc search results
   logic [31:0]       mask_ff;
   logic [32:0]       need_ff;
   logic              bf_ff, sf_ff;
   logic [IDX_W-1:0]  bidx_ff, sidx_ff;
   hole_type          best_ff;
   logic [31:0]       tot_ff, al_ff;

   // free search results
   logic              mf_ff, pf_ff, nf_ff;
   logic [IDX_W-1:0]  midx_ff, pidx_ff, nidx_ff;
   hole_type          m_ff, p_ff, n_ff;

   // write-back queue
   logic [1:0]        wcnt_ff, wpos_ff;
   logic [IDX_W-1:0]  waddr_ff [3];
   hole_type          wdata_ff [3];

   logic              ram_we;
   logic [IDX_W-1:0]  ram_wa, ram_ra;
   hole_type          ram_wd, rd;

   ffa_ram #(.WIDTH(HW), .DEPTH(DESC_COUNT)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (rd)
   );

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign ram_ra    = saddr_ff;

   // RAM write: clearing pass or queued write-back
   always_comb begin
      ram_we = 1'b0;
      ram_wa = clr_ff;
      ram_wd = '0;
      if (state_ff == S_CLEAR) begin
         ram_we = 1'b1;
         if (clr_ff == '0) begin
            ram_wd.kind   = KIND_FREE;
            ram_wd.base   = pool_base_ff;
            ram_wd.length = pool_len_ff;
         end
      end else if (state_ff == S_WRITE) begin
         ram_we = 1'b1;
         ram_wa = waddr_ff[wpos_ff];
         ram_wd = wdata_ff[wpos_ff];
      end
   end

   // per-entry fit test for allocate
   logic [32:0] e_al;
   logic [33:0] e_tot;
   logic        e_fit;
   always_comb begin
      e_al  = ({1'b0, rd.base} + {1'b0, mask_ff}) & ~{1'b0, mask_ff};
      e_tot = {1'b0, e_al} - {2'b0, rd.base} + {1'b0, need_ff};
      e_fit = (rd.kind == KIND_FREE) && !e_al[32] && (e_tot <= {2'b0, rd.length});
   end

   // free decision terms
   logic [32:0] m_end, p_end;
   logic        ovl, pj, nj;
   always_comb begin
      m_end = {1'b0, m_ff.base} + {1'b0, m_ff.length};
      p_end = {1'b0, p_ff.base} + {1'b0, p_ff.length};
      ovl   = nf_ff && (m_end > {1'b0, n_ff.base});
      pj    = pf_ff && (p_end == {1'b0, m_ff.base});
      nj    = nf_ff && (m_end == {1'b0, n_ff.base});
   end

   // alloc decision terms
   logic [31:0] rem;
   logic [5:0]  expo;
   logic [31:0] nmask;
   logic [32:0] nneed;
   always_comb begin
      rem   = best_ff.length - tot_ff;
      expo  = (req_payload.mode == MODE_ALLOC) ? 6'd0 : req_payload.align_exponent;
      nmask = (32'd1 << expo[4:0]) - 32'd1;
      nneed = ({1'b0, req_payload.request_size} + {1'b0, nmask}) & ~{1'b0, nmask};
   end

   always_ff @(posedge clock) begin
      rsp_valid <= 1'b0;
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pool_base_ff <= '0;
         pool_len_ff  <= '0;
         min_split_ff <= 32'd16;
         issue_ff     <= 1'b0;
         dv_ff        <= 1'b0;
         dlast_ff     <= 1'b0;
         saddr_ff     <= '0;
         wcnt_ff      <= '0;
         wpos_ff      <= '0;
      end else begin
         // scan engine steps in every scan state
         if (issue_ff) begin
            dv_ff    <= 1'b1;
            didx_ff  <= saddr_ff;
            dlast_ff <= (saddr_ff == LAST_IDX);
            issue_ff <= (saddr_ff != LAST_IDX);
            saddr_ff <= saddr_ff + IDX_W'(1);
         end else begin
            dv_ff <= 1'b0;
         end

         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + IDX_W'(1);
               if (clr_ff == LAST_IDX) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  req_ff   <= req_payload;
                  saddr_ff <= '0;
                  issue_ff <= 1'b1;
                  dv_ff    <= 1'b0;
                  mask_ff  <= nmask;
                  need_ff  <= nneed;
                  bf_ff    <= 1'b0;
                  sf_ff    <= 1'b0;
                  mf_ff    <= 1'b0;
                  if (req_payload.mode == MODE_ALLOC || req_payload.mode == MODE_ALLOC_AL) begin
                     if (expo[5] || nneed[32]) begin
                        issue_ff      <= 1'b0;
                        rsp_valid     <= 1'b1;
                        rsp_payload.granted_address <= '0;
                        rsp_payload.status <= expo[5] ? ST_BADALIGN : ST_NOFIT;
                     end else begin
                        state_ff <= S_ASCAN;
                     end
                  end else begin
                     state_ff <= S_MSCAN;
                  end
               end
            end
            S_ASCAN: begin
               if (dv_ff) begin
                  if (e_fit && (!bf_ff || rd.base < best_ff.base)) begin
                     bf_ff   <= 1'b1;
                     bidx_ff <= didx_ff;
                     best_ff <= rd;
                     tot_ff  <= e_tot[31:0];
                     al_ff   <= e_al[31:0];
                  end
                  if (rd.kind == KIND_SPARE && !sf_ff) begin
                     sf_ff   <= 1'b1;
                     sidx_ff <= didx_ff;
                  end
                  if (dlast_ff) begin
                     state_ff <= S_ADEC;
                  end
               end
            end
            S_ADEC: begin
               rsp_payload.granted_address <= '0;
               wpos_ff <= '0;
               if (!bf_ff) begin
                  rsp_valid  <= 1'b1;
                  rsp_payload.status <= ST_NOFIT;
                  state_ff   <= S_IDLE;
               end else if (rem > min_split_ff) begin
                  if (!sf_ff) begin
                     rsp_valid  <= 1'b1;
                     rsp_payload.status <= ST_NODESC;
                     state_ff   <= S_IDLE;
                  end else begin
                     waddr_ff[0]              <= sidx_ff;
                     wdata_ff[0].kind         <= KIND_USED;
                     wdata_ff[0].base         <= best_ff.base;
                     wdata_ff[0].length       <= tot_ff;
                     wdata_ff[0].aligned_base <= al_ff;
                     waddr_ff[1]              <= bidx_ff;
                     wdata_ff[1].kind         <= KIND_FREE;
                     wdata_ff[1].base         <= best_ff.base + tot_ff;
                     wdata_ff[1].length       <= rem;
                     wdata_ff[1].aligned_base <= best_ff.aligned_base;
                     wcnt_ff                  <= 2'd1;
                     state_ff                 <= S_WRITE;
                  end
               end else begin
                  waddr_ff[0] <= bidx_ff;
                  wdata_ff[0] <= {KIND_USED, al_ff, best_ff.length, best_ff.base};
                  wcnt_ff     <= 2'd0;
                  state_ff    <= S_WRITE;
               end
            end
            S_MSCAN: begin
               if (dv_ff) begin
                  if (!mf_ff && rd.kind == KIND_USED &&
                      (((req_ff.mode == MODE_FREE_AL) ? rd.aligned_base : rd.base)
                       == req_ff.block_address)) begin
                     mf_ff   <= 1'b1;
                     midx_ff <= didx_ff;
                     m_ff    <= rd;
                  end
                  if (dlast_ff) begin
                     state_ff <= S_NSTART;
                  end
               end
            end
            S_NSTART: begin
               pf_ff <= 1'b0;
               nf_ff <= 1'b0;
               if (!mf_ff) begin
                  rsp_valid           <= 1'b1;
                  rsp_payload.granted_address <= '0;
                  rsp_payload.status  <= ST_NOTALLOC;
                  state_ff            <= S_IDLE;
               end else begin
                  saddr_ff <= '0;
                  issue_ff <= 1'b1;
                  dv_ff    <= 1'b0;
                  state_ff <= S_NSCAN;
               end
            end
            S_NSCAN: begin
               if (dv_ff) begin
                  if (rd.kind == KIND_FREE) begin
                     if (rd.base > m_ff.base) begin
                        if (!nf_ff || rd.base < n_ff.base) begin
                           nf_ff   <= 1'b1;
                           nidx_ff <= didx_ff;
                           n_ff    <= rd;
                        end
                     end else if (!pf_ff || rd.base >= p_ff.base) begin
                        pf_ff   <= 1'b1;
                        pidx_ff <= didx_ff;
                        p_ff    <= rd;
                     end
                  end
                  if (dlast_ff) begin
                     state_ff <= S_FDEC;
                  end
               end
            end
            S_FDEC: begin
               rsp_payload.granted_address <= '0;
               wpos_ff <= '0;
               if (ovl) begin
                  rsp_valid  <= 1'b1;
                  rsp_payload.status <= ST_OVERLAP;
                  state_ff   <= S_IDLE;
               end else begin
                  state_ff <= S_WRITE;
                  if (pj && nj) begin
                     waddr_ff[0] <= pidx_ff;
                     wdata_ff[0] <= {p_ff.kind, p_ff.aligned_base,
                                     p_ff.length + m_ff.length + n_ff.length, p_ff.base};
                     waddr_ff[1] <= midx_ff;
                     wdata_ff[1] <= '0;
                     waddr_ff[2] <= nidx_ff;
                     wdata_ff[2] <= '0;
                     wcnt_ff     <= 2'd2;
                  end else if (pj) begin
                     waddr_ff[0] <= pidx_ff;
                     wdata_ff[0] <= {p_ff.kind, p_ff.aligned_base,
                                     p_ff.length + m_ff.length, p_ff.base};
                     waddr_ff[1] <= midx_ff;
                     wdata_ff[1] <= '0;
                     wcnt_ff     <= 2'd1;
                  end else if (nj) begin
                     waddr_ff[0] <= midx_ff;
                     wdata_ff[0] <= {KIND_FREE, m_ff.aligned_base,
                                     m_ff.length + n_ff.length, m_ff.base};
                     waddr_ff[1] <= nidx_ff;
                     wdata_ff[1] <= '0;
                     wcnt_ff     <= 2'd1;
                  end else begin
                     waddr_ff[0] <= midx_ff;
                     wdata_ff[0] <= {KIND_FREE, m_ff.aligned_base, m_ff.length, m_ff.base};
                     wcnt_ff     <= 2'd0;
                  end
               end
            end
            S_WRITE: begin
               wpos_ff <= wpos_ff + 2'd1;
               if (wpos_ff == wcnt_ff) begin
                  rsp_valid  <= 1'b1;
                  rsp_payload.status <= ST_OK;
                  rsp_payload.granted_address <=
                     (req_ff.mode == MODE_ALLOC || req_ff.mode == MODE_ALLOC_AL) ? al_ff : '0;
                  state_ff   <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase

         // configuration writes; pool changes rebuild the table
         if (csr_valid) begin
            unique case (csr_index)
               CSR_POOL_BASE: begin
                  pool_base_ff <= csr_data;
                  clr_ff       <= '0;
                  issue_ff     <= 1'b0;
                  state_ff     <= S_CLEAR;
               end
               CSR_POOL_LEN: begin
                  pool_len_ff  <= csr_data;
                  clr_ff       <= '0;
                  issue_ff     <= 1'b0;
                  state_ff     <= S_CLEAR;
               end
               CSR_MIN_SPLIT: min_split_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

endmodule

`default_nettype wire
